// ----- rtl/huffman_lookup_table_decoder_defines.svh -----
// huffman_lookup_table_decoder_defines.svh
// Assertion macros for the table-driven Huffman decoder RTL.
// No dependencies; expects clk and rst_n in the including module.
`ifndef HUFFMAN_LOOKUP_TABLE_DECODER_DEFINES_SVH
`define HUFFMAN_LOOKUP_TABLE_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset
`define HLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next
`define HLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HLD_ASSERT(lbl, prop, msg)
`define HLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/hltd_pkg.sv -----
// hltd_pkg.sv
// Shared widths, reset values, codes and structs for the Huffman decoder.
// No dependencies.
`default_nettype none

package hltd_pkg;

  // Parameter defaults
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int TABLE_SETS_DEF    = 3;

  // Fixed field widths
  localparam int VALUE_W   = 16;
  localparam int LEN_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int SEL_W     = 2;
  localparam int CL_W      = 4;
  localparam int FRAME_W   = 20;
  localparam int ENTRY_W   = VALUE_W + LEN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = FRAME_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration reset values
  localparam logic [SEL_W-1:0]   SEL_RESET   = 2'd0;
  localparam logic [CL_W-1:0]    CL_RESET    = 4'd12;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 20'd307200;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SELECT  = 2'd0,
    CFG_CODE_LENGTH   = 2'd1,
    CFG_FRAME_SAMPLES = 2'd2
  } cfg_idx_t;

  // Input operation codes
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

  // Classified item from front to back
  typedef struct packed {
    op_t                       op;
    logic                      load_ok;
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          length;
    logic [BYTE_W-1:0]         stream_bits;
    logic                      fin;
  } cmd_t;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [SEL_W-1:0]   set;
    logic [CL_W-1:0]    cl;
    logic [FRAME_W-1:0] limit;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          used;
    logic                      bad;
    logic                      fend;
    logic                      shrt;
    logic                      last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/hltd_front.sv -----
// hltd_front.sv
// Front end: takes input transfers, classifies load vs. stream byte and
// range-checks load addresses. Depends on hltd_pkg.
`default_nettype none

module hltd_front #(
  parameter int MAX_CODE_BITS = hltd_pkg::MAX_CODE_BITS_DEF,
  parameter int TABLE_SETS    = hltd_pkg::TABLE_SETS_DEF
) (
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_operation,
  input  wire logic [MAX_CODE_BITS+1:0]            in_table_index,
  input  wire logic signed [hltd_pkg::VALUE_W-1:0] in_entry_value,
  input  wire logic [hltd_pkg::LEN_W-1:0]          in_entry_length,
  input  wire logic [hltd_pkg::BYTE_W-1:0]         in_stream_byte,
  input  wire logic                                in_final_byte,
  output logic                                     push_valid,
  input  wire logic                                push_ready,
  output hltd_pkg::cmd_t                           push_cmd,
  output logic [MAX_CODE_BITS+1:0]                 push_addr
);

  localparam int IDX_W       = MAX_CODE_BITS + 2;
  localparam int CMP_W       = IDX_W + 1;
  localparam int TABLE_DEPTH = TABLE_SETS << MAX_CODE_BITS;

  // Handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign push_addr  = in_table_index;

  // Classify and check the load address against the table depth
  always_comb begin
    push_cmd             = '0;
    push_cmd.op          = hltd_pkg::op_t'(in_operation);
    push_cmd.load_ok     = ({1'b0, in_table_index} < CMP_W'(TABLE_DEPTH));
    push_cmd.value       = in_entry_value;
    push_cmd.length      = in_entry_length;
    push_cmd.stream_bits = in_stream_byte;
    push_cmd.fin         = in_final_byte;
  end

endmodule

`default_nettype wire

// ----- rtl/hltd_queue.sv -----
// hltd_queue.sv
// Short FIFO decoupling the front end from the decode engine.
// Depends on hltd_pkg and the assertion macro header.
`default_nettype none
`include "huffman_lookup_table_decoder_defines.svh"

module hltd_queue #(
  parameter int ADDR_W = hltd_pkg::MAX_CODE_BITS_DEF + 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire hltd_pkg::cmd_t    push_cmd,
  input  wire logic [ADDR_W-1:0] push_addr,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output hltd_pkg::cmd_t         pop_cmd,
  output logic [ADDR_W-1:0]      pop_addr
);

  localparam int DEPTH = hltd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hltd_pkg::cmd_t    cmd_r  [DEPTH];
  logic [ADDR_W-1:0] addr_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_fire, pop_fire;

  assign push_ready = (count_r < CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_cmd    = cmd_r[rd_ptr_r];
  assign pop_addr   = addr_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      cmd_r[wr_ptr_r]  <= push_cmd;
      addr_r[wr_ptr_r] <= push_addr;
    end
  end

  `HLD_ASSERT(a_queue_count_bound, count_r <= CNT_W'(DEPTH), "queue occupancy above depth")

endmodule

`default_nettype wire

// ----- rtl/hltd_back.sv -----
// hltd_back.sv
// Decode engine: code table memory, bit buffer, frame counter and output
// register. Depends on hltd_pkg and the assertion macro header.
`default_nettype none
`include "huffman_lookup_table_decoder_defines.svh"

module hltd_back #(
  parameter int MAX_CODE_BITS = hltd_pkg::MAX_CODE_BITS_DEF,
  parameter int TABLE_SETS    = hltd_pkg::TABLE_SETS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hltd_pkg::cfg_t           cfg,
  input  wire logic                     pop_valid,
  output logic                          pop_ready,
  input  wire hltd_pkg::cmd_t           pop_cmd,
  input  wire logic [MAX_CODE_BITS+1:0] pop_addr,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output hltd_pkg::res_t                out_res
);

  localparam int MCB      = MAX_CODE_BITS;
  localparam int DEPTH    = TABLE_SETS << MCB;
  localparam int MEM_AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BUF_W    = MCB + 7;
  localparam int HELD_W   = $clog2(MCB + 8);
  localparam int SHIFT_W  = BUF_W + MCB;
  localparam int SH_AMT_W = $clog2(SHIFT_W + 1);
  localparam int MASK_W   = MCB + 1;
  localparam int FULL_W   = hltd_pkg::SEL_W + MCB;
  localparam int LEN_W    = hltd_pkg::LEN_W;
  localparam int CL_W     = hltd_pkg::CL_W;
  localparam int FRAME_W  = hltd_pkg::FRAME_W;
  localparam int ENTRY_W  = hltd_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [FRAME_W-1:0]   samples_r, samples_nxt;
  logic                 fin_r, fin_nxt;
  logic                 out_valid_r;
  hltd_pkg::res_t       res_r, res_nxt;
  logic                 emit, out_free;

  logic [ENTRY_W-1:0]   code_table_mem [DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic                 mem_we, mem_re;
  logic [MEM_AW-1:0]    wr_addr, rd_addr;
  logic [FULL_W-1:0]    rd_full;
  logic [MCB-1:0]       rd_idx, cur_idx, nxt_idx;

  // Decode of the entry just read
  logic [LEN_W-1:0]     ent_len, used;
  logic                 bad;
  logic [HELD_W-1:0]    held_dec;
  logic [BUF_W-1:0]     buf_dec;
  logic [FRAME_W-1:0]   samples_dec;
  logic                 more_bits, under, cont, can_decode;

  // Byte append
  logic [HELD_W-1:0]    held_app;
  logic [BUF_W-1:0]     buf_app;

  // Peek cl bits, MSB first, zero-padded below when fewer bits are held
  function automatic logic [MCB-1:0] peek(input logic [BUF_W-1:0] b,
                                          input logic [HELD_W-1:0] h,
                                          input logic [CL_W-1:0] c);
    logic [SHIFT_W-1:0]  ext;
    logic [SH_AMT_W-1:0] amt;
    logic [SHIFT_W-1:0]  sh;
    logic [MASK_W-1:0]   m;
    ext = {b, {MCB{1'b0}}};
    amt = SH_AMT_W'(h) + SH_AMT_W'(MCB) - SH_AMT_W'(c);
    sh  = ext >> amt;
    m   = (MASK_W'(1) << c) - MASK_W'(1);
    return sh[MCB-1:0] & m[MCB-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Entry fields and next buffer state after this code
  assign ent_len     = rd_data_r[LEN_W-1:0];
  assign bad         = (ent_len == '0) || (ent_len > cfg.cl);
  assign used        = bad ? cfg.cl : ent_len;
  assign held_dec    = (HELD_W'(used) >= held_r) ? '0 : held_r - HELD_W'(used);
  assign buf_dec     = buf_r & ~({BUF_W{1'b1}} << held_dec);
  assign samples_dec = samples_r + 1'b1;
  assign under       = (samples_dec < cfg.limit);
  assign more_bits   = (held_dec >= HELD_W'(cfg.cl)) || (fin_r && (held_dec != '0));
  assign cont        = more_bits && under;

  // Decode possible right after a byte is appended
  assign can_decode  = (samples_r < cfg.limit) &&
                       ((held_r >= HELD_W'(cfg.cl)) || (fin_r && (held_r != '0)));

  assign held_app = held_r + HELD_W'(hltd_pkg::BYTE_W);
  assign buf_app  = BUF_W'({buf_r, pop_cmd.stream_bits});

  // Table read address: current buffer, or buffer after the code in flight
  assign cur_idx = peek(buf_r, held_r, cfg.cl);
  assign nxt_idx = peek(buf_dec, held_dec, cfg.cl);
  assign rd_full = {cfg.set, rd_idx};
  assign rd_addr = rd_full[MEM_AW-1:0];
  assign wr_addr = pop_addr[MEM_AW-1:0];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    buf_nxt     = buf_r;
    held_nxt    = held_r;
    samples_nxt = samples_r;
    fin_nxt     = fin_r;
    pop_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_idx      = cur_idx;
    emit        = 1'b0;
    res_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_cmd.op == hltd_pkg::OP_LOAD) begin
            mem_we = pop_cmd.load_ok;
          end else if (samples_r >= cfg.limit) begin
            // Frame complete: drop the byte, a final byte reopens the frame
            buf_nxt  = '0;
            held_nxt = '0;
            if (pop_cmd.fin) begin
              samples_nxt = '0;
            end
          end else begin
            buf_nxt   = buf_app;
            held_nxt  = held_app;
            fin_nxt   = pop_cmd.fin;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (can_decode) begin
          mem_re    = 1'b1;
          state_nxt = S_EMIT;
        end else if (fin_r) begin
          // Final byte with no code: short-frame marker
          if (out_free) begin
            emit         = 1'b1;
            res_nxt.fend = 1'b1;
            res_nxt.shrt = 1'b1;
            res_nxt.last = 1'b1;
            buf_nxt      = '0;
            held_nxt     = '0;
            samples_nxt  = '0;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          res_nxt.value = rd_data_r[ENTRY_W-1:LEN_W];
          res_nxt.used  = used;
          res_nxt.bad   = bad;
          res_nxt.last  = !cont;
          res_nxt.fend  = !under || (!cont && fin_r);
          res_nxt.shrt  = !cont && fin_r && under;
          buf_nxt       = buf_dec;
          held_nxt      = held_dec;
          samples_nxt   = samples_dec;
          if (cont) begin
            rd_idx = nxt_idx;
            mem_re = 1'b1;
          end else begin
            if (!under || fin_r) begin
              buf_nxt  = '0;
              held_nxt = '0;
            end
            if (fin_r) begin
              samples_nxt = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= '0;
      held_r      <= '0;
      samples_r   <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      samples_r   <= samples_nxt;
      fin_r       <= fin_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  // Code table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      code_table_mem[wr_addr] <= {pop_cmd.value, pop_cmd.length};
    end
    if (mem_re) begin
      rd_data_r <= code_table_mem[rd_addr];
    end
  end

  `HLD_ASSERT(a_held_fits, held_r <= HELD_W'(BUF_W), "bit count exceeds buffer")
  `HLD_ASSERT(a_emit_has_room, emit |-> (!out_valid_r || out_ready), "result overwritten")
  `HLD_ASSERT_NEXT(a_read_then_emit, mem_re, state_r == S_EMIT, "table read without emit")
  `HLD_ASSERT_NEXT(a_last_ends_run, emit && res_nxt.last, state_r == S_IDLE, "run kept going")

endmodule

`default_nettype wire

// ----- rtl/huffman_lookup_table_decoder.sv -----
// huffman_lookup_table_decoder.sv
// Top level: configuration registers, front end, queue and decode engine.
// Depends on hltd_pkg, hltd_front, hltd_queue and hltd_back.
//
//  Channel  Direction  Handshake            Moves
//  in_      input      in_valid/in_ready    table load or stream byte
//  out_     output     out_valid/out_ready  one decoded value per transfer
//  cfg_     input      cfg_we               register write, no wait
//
// A load is written in the idle state. A stream byte is appended there, the
// check state starts the table read and the emit state outputs each decoded
// code: the table read is registered and the next read address is formed from
// the entry just read. A byte after frame end is dropped. Reset is synchronous;
// the code table has no reset and holds garbage until loaded. A two-entry queue
// and the output register let input and output stall independently.
`default_nettype none

module huffman_lookup_table_decoder #(
  parameter int MAX_CODE_BITS = hltd_pkg::MAX_CODE_BITS_DEF,
  parameter int TABLE_SETS    = hltd_pkg::TABLE_SETS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [hltd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hltd_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_operation,
  input  wire logic [MAX_CODE_BITS+1:0]            in_table_index,
  input  wire logic signed [hltd_pkg::VALUE_W-1:0] in_entry_value,
  input  wire logic [hltd_pkg::LEN_W-1:0]          in_entry_length,
  input  wire logic [hltd_pkg::BYTE_W-1:0]         in_stream_byte,
  input  wire logic                                in_final_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [hltd_pkg::VALUE_W-1:0]      out_sample_value,
  output logic [hltd_pkg::LEN_W-1:0]               out_bits_used,
  output logic                                     out_bad_entry,
  output logic                                     out_frame_end,
  output logic                                     out_short_frame,
  output logic                                     out_last_of_run
);

  localparam int IDX_W   = MAX_CODE_BITS + 2;
  localparam int SEL_W   = hltd_pkg::SEL_W;
  localparam int CL_W    = hltd_pkg::CL_W;
  localparam int FRAME_W = hltd_pkg::FRAME_W;
  localparam int SCMP_W  = SEL_W + 1;
  localparam int CCMP_W  = CL_W + 1;

  logic [SEL_W-1:0]   sel_r;
  logic [CL_W-1:0]    cl_r;
  logic [FRAME_W-1:0] frame_r;
  hltd_pkg::cfg_t     cfg_eff;

  logic               push_valid, push_ready;
  hltd_pkg::cmd_t     push_cmd;
  logic [IDX_W-1:0]   push_addr;
  logic               pop_valid, pop_ready;
  hltd_pkg::cmd_t     pop_cmd;
  logic [IDX_W-1:0]   pop_addr;
  hltd_pkg::res_t     out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= hltd_pkg::SEL_RESET;
      cl_r    <= hltd_pkg::CL_RESET;
      frame_r <= hltd_pkg::FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hltd_pkg::CFG_TABLE_SELECT:  sel_r   <= cfg_data[SEL_W-1:0];
        hltd_pkg::CFG_CODE_LENGTH:   cl_r    <= cfg_data[CL_W-1:0];
        hltd_pkg::CFG_FRAME_SAMPLES: frame_r <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp configuration to legal values
  always_comb begin
    cfg_eff.set = ({1'b0, sel_r} >= SCMP_W'(TABLE_SETS)) ? SEL_W'(TABLE_SETS - 1) : sel_r;
    if (cl_r == '0) begin
      cfg_eff.cl = CL_W'(1);
    end else if ({1'b0, cl_r} > CCMP_W'(MAX_CODE_BITS)) begin
      cfg_eff.cl = CL_W'(MAX_CODE_BITS);
    end else begin
      cfg_eff.cl = cl_r;
    end
    cfg_eff.limit = (frame_r == '0) ? FRAME_W'(1) : frame_r;
  end

  hltd_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .TABLE_SETS    (TABLE_SETS)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_table_index  (in_table_index),
    .in_entry_value  (in_entry_value),
    .in_entry_length (in_entry_length),
    .in_stream_byte  (in_stream_byte),
    .in_final_byte   (in_final_byte),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd),
    .push_addr       (push_addr)
  );

  hltd_queue #(
    .ADDR_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .pop_addr   (pop_addr)
  );

  hltd_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .TABLE_SETS    (TABLE_SETS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .pop_addr  (pop_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields to ports
  assign out_sample_value = out_res.value;
  assign out_bits_used    = out_res.used;
  assign out_bad_entry    = out_res.bad;
  assign out_frame_end    = out_res.fend;
  assign out_short_frame  = out_res.shrt;
  assign out_last_of_run  = out_res.last;

endmodule

`default_nettype wire
